@@ sv/chis_pkg.sv @@
// Shared types and constants for the chained hash integer set.
// Used by every module of the block but chis_checker; depends on nothing.
package chis_pkg;

    localparam int BUCKET_DEPTH = 1280;
    localparam int NODE_DEPTH   = 1024;
    localparam int BKT_AW       = $clog2(BUCKET_DEPTH);
    localparam int DIV_W        = $clog2(BUCKET_DEPTH + 1);
    localparam int NODE_AW      = $clog2(NODE_DEPTH);
    localparam int LINK_W       = $clog2(NODE_DEPTH + 1);
    localparam int KEY_W        = 31;
    localparam int CFG_W        = 11;
    localparam int CNT_W        = 11;
    localparam int STEP_W       = $clog2(KEY_W);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_MAX     = 1'b1;

    typedef struct packed {
        t_cmd              cmd;
        logic [KEY_W-1:0]  key;
        logic [BKT_AW-1:0] bucket;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic              v;
        logic [KEY_W-1:0]  key;
        logic [LINK_W-1:0] link;
    } t_bkt;

endpackage

@@ sv/chained_hash_integer_set_core.sv @@
// Top level of the chained hash integer set: stream ports, APB registers.
// Depends on chis_pkg, chis_front, chis_fifo and chis_back.
//
// Keeps a set of 31-bit keys in a table of 1280 buckets hashed by key modulo
// table_modulus; the first key of a bucket sits in the bucket itself and
// colliding keys chain through a pool of 1024 overflow nodes. A command
// transfer (tuser = command, tdata = key) yields one result transfer, unless
// a register write cuts it short. The front end takes a transfer and works
// out a bit-serial remainder, then hands the item through a two-entry queue
// to the back end, which reads the bucket and walks the chain one node per
// cycle. The serial remainder sets the sustained rate while the back end
// keeps up: the front end takes no new transfer until its item is pushed. A
// clear command, any write to a register and the release of reset start a
// sweep over all 1280 buckets; no command transfer is taken during it. Writing
// either register empties the set. Registers: 0x0 table_modulus (0 acts as
// 1, above 1280 acts as 1280), 0x4 max_entries.
module chained_hash_integer_set_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] key, [31] ignored
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] status, [2] member, [13:3] entry_total
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [chis_pkg::CFG_W-1:0] r_table_modulus;
    logic [chis_pkg::CFG_W-1:0] r_max_entries;
    logic                       cfg_wr;
    logic                       clearing;
    logic                       push, pop;
    chis_pkg::t_item            push_item, head;
    chis_pkg::t_q_stat          q_stat;
    logic [1:0]                 status;
    logic                       member;
    logic [chis_pkg::CNT_W-1:0] total;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register file: address bit 2 picks the register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_modulus <= chis_pkg::CFG_W'(1);
            r_max_entries   <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == chis_pkg::REG_MODULUS) begin
                r_table_modulus <= pwdata[chis_pkg::CFG_W-1:0];
            end else begin
                r_max_entries <= pwdata[chis_pkg::CFG_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            chis_pkg::REG_MODULUS: prdata = 32'(r_table_modulus);
            chis_pkg::REG_MAX:     prdata = 32'(r_max_entries);
            default:               prdata = '0;
        endcase
    end

    chis_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_cmd     (chis_pkg::t_cmd'(s_axis_tuser)),
        .i_key     (s_axis_tdata[chis_pkg::KEY_W-1:0]),
        .i_modulus (r_table_modulus),
        .i_hold    (clearing),
        .i_q       (q_stat),
        .o_push    (push),
        .o_item    (push_item)
    );

    chis_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    chis_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (q_stat),
        .i_head     (head),
        .o_pop      (pop),
        .i_max      (r_max_entries),
        .i_cfg_clr  (cfg_wr),
        .o_clearing (clearing),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_status   (status),
        .o_member   (member),
        .o_total    (total)
    );

    assign m_axis_tdata = {2'b00, total, member, status};

endmodule

@@ sv/chis_front.sv @@
// Front end: takes command transfers and works out the bucket by serial modulo.
// Depends on chis_pkg.
module chis_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  chis_pkg::t_cmd             i_cmd,
    input  logic [chis_pkg::KEY_W-1:0] i_key,
    input  logic [chis_pkg::CFG_W-1:0] i_modulus,
    input  logic                       i_hold,
    input  chis_pkg::t_q_stat          i_q,
    output logic                       o_push,
    output chis_pkg::t_item            o_item
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                        r_state, n_state;
    chis_pkg::t_cmd                 r_cmd;
    logic [chis_pkg::KEY_W-1:0]     r_key;
    logic [chis_pkg::KEY_W-1:0]     r_sh;
    logic [chis_pkg::DIV_W-1:0]     r_rem;
    logic [chis_pkg::STEP_W-1:0]    r_cnt;
    logic [chis_pkg::DIV_W-1:0]     m;
    logic [chis_pkg::DIV_W:0]       trial;
    logic [chis_pkg::DIV_W:0]       diff;
    logic                           accept;

    // effective modulus: zero acts as one, oversize clamps to the table
    always_comb begin
        if (32'(i_modulus) > 32'(chis_pkg::BUCKET_DEPTH)) begin
            m = chis_pkg::DIV_W'(chis_pkg::BUCKET_DEPTH);
        end else if (i_modulus == '0) begin
            m = chis_pkg::DIV_W'(1);
        end else begin
            m = chis_pkg::DIV_W'(i_modulus);
        end
    end

    assign trial  = {r_rem, r_sh[chis_pkg::KEY_W-1]};
    assign diff   = trial - {1'b0, m};
    assign o_ready = (r_state == F_IDLE) && !i_hold;
    assign accept = i_valid && o_ready;
    assign o_push = (r_state == F_PUSH) && !i_q.full;
    assign o_item = '{cmd: r_cmd, key: r_key, bucket: r_rem[chis_pkg::BKT_AW-1:0]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) n_state = F_DIV;
            end
            F_DIV: begin
                if (r_cnt == chis_pkg::STEP_W'(chis_pkg::KEY_W - 1)) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_q.full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_sh  <= i_key;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == F_DIV) begin
            r_sh  <= {r_sh[chis_pkg::KEY_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (trial >= {1'b0, m}) begin
                r_rem <= diff[chis_pkg::DIV_W-1:0];
            end else begin
                r_rem <= trial[chis_pkg::DIV_W-1:0];
            end
        end
    end

endmodule

@@ sv/chis_fifo.sv @@
// Two-entry queue between front and back ends.
// Depends on chis_pkg.
module chis_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  chis_pkg::t_item   i_item,
    input  logic              i_pop,
    output chis_pkg::t_item   o_head,
    output chis_pkg::t_q_stat o_stat
);

    chis_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

@@ sv/chis_back.sv @@
// Back end: bucket table, overflow node pool, free stack and result register.
// Depends on chis_pkg.
module chis_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  chis_pkg::t_q_stat          i_q,
    input  chis_pkg::t_item            i_head,
    output logic                       o_pop,
    input  logic [chis_pkg::CFG_W-1:0] i_max,
    input  logic                       i_cfg_clr,
    output logic                       o_clearing,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic                       o_member,
    output logic [chis_pkg::CNT_W-1:0] o_total
);

    typedef enum logic [6:0] {
        S_CLR    = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_BKT    = 7'b0000100,
        S_NODE   = 7'b0001000,
        S_HEADRM = 7'b0010000,
        S_ALLOC  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_bstate;

    localparam int LW = chis_pkg::LINK_W;
    localparam int NW = chis_pkg::NODE_AW;

    // memories
    chis_pkg::t_bkt               bkt_mem  [chis_pkg::BUCKET_DEPTH];
    logic [chis_pkg::KEY_W-1:0]   nkey_mem [chis_pkg::NODE_DEPTH];
    logic [LW-1:0]                nlnk_mem [chis_pkg::NODE_DEPTH];
    logic [NW-1:0]                stk_mem  [chis_pkg::NODE_DEPTH];

    chis_pkg::t_bkt               r_bkt_q;
    logic [chis_pkg::KEY_W-1:0]   r_nkey_q;
    logic [LW-1:0]                r_nlnk_q;
    logic [NW-1:0]                r_stk_q;

    t_bstate                      r_state, n_state;
    chis_pkg::t_item              r_item, n_item;
    logic [chis_pkg::KEY_W-1:0]   r_hk, n_hk;
    logic [LW-1:0]                r_hl, n_hl;
    logic [LW-1:0]                r_l, n_l;
    logic [LW-1:0]                r_prev, n_prev;
    logic [1:0]                   r_status, n_status;
    logic                         r_member, n_member;
    logic [chis_pkg::CNT_W-1:0]   r_held, n_held;
    logic [LW-1:0]                r_fresh, n_fresh;
    logic [LW-1:0]                r_freed, n_freed;
    logic [chis_pkg::BKT_AW-1:0]  r_clr_idx, n_clr_idx;
    logic                         r_clr_res, n_clr_res;
    logic                         r_out_valid, n_out_valid;
    logic [1:0]                   r_out_status, n_out_status;
    logic                         r_out_member, n_out_member;
    logic [chis_pkg::CNT_W-1:0]   r_out_total, n_out_total;

    logic                         bkt_we;
    logic [chis_pkg::BKT_AW-1:0]  bkt_waddr;
    chis_pkg::t_bkt               bkt_wdata;
    logic                         nkey_we, nlnk_we;
    logic [NW-1:0]                node_waddr;
    logic [LW-1:0]                node_wlink;
    logic [NW-1:0]                node_raddr;
    logic                         stk_we;
    logic [NW-1:0]                stk_wdata;
    logic [NW-1:0]                stk_raddr;

    logic                         miss, link_go, free_go;
    logic [NW-1:0]                link_n, free_n;
    logic [chis_pkg::KEY_W-1:0]   hk_now;
    logic [LW-1:0]                hl_now;
    logic                         none_free, at_limit;

    assign none_free  = (r_fresh == LW'(chis_pkg::NODE_DEPTH)) && (r_freed == '0);
    assign at_limit   = r_held >= i_max;
    assign hk_now     = (r_state == S_BKT) ? r_bkt_q.key  : r_hk;
    assign hl_now     = (r_state == S_BKT) ? r_bkt_q.link : r_hl;
    assign stk_raddr  = r_freed[NW-1:0] - 1'b1;
    assign o_clearing = (r_state == S_CLR);
    assign o_pop      = (r_state == S_IDLE) && !i_q.empty && !i_cfg_clr;
    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_member   = r_out_member;
    assign o_total    = r_out_total;

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_hk         = r_hk;
        n_hl         = r_hl;
        n_l          = r_l;
        n_prev       = r_prev;
        n_status     = r_status;
        n_member     = r_member;
        n_held       = r_held;
        n_fresh      = r_fresh;
        n_freed      = r_freed;
        n_clr_idx    = r_clr_idx;
        n_clr_res    = r_clr_res;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_member = r_out_member;
        n_out_total  = r_out_total;
        bkt_we       = 1'b0;
        bkt_waddr    = r_item.bucket;
        bkt_wdata    = '0;
        nkey_we      = 1'b0;
        nlnk_we      = 1'b0;
        node_waddr   = '0;
        node_wlink   = '0;
        node_raddr   = '0;
        stk_we       = 1'b0;
        stk_wdata    = '0;
        miss         = 1'b0;
        link_go      = 1'b0;
        link_n       = '0;
        free_go      = 1'b0;
        free_n       = '0;

        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_item = i_head;
                    if (i_head.cmd == chis_pkg::CMD_CLEAR) begin
                        n_state   = S_CLR;
                        n_clr_idx = '0;
                        n_clr_res = 1'b1;
                    end else begin
                        n_state = S_BKT;
                    end
                end
            end
            S_BKT: begin
                n_hk = r_bkt_q.key;
                n_hl = r_bkt_q.link;
                if (!r_bkt_q.v) begin
                    if (r_item.cmd == chis_pkg::CMD_INSERT) begin
                        if (at_limit) begin
                            n_status = chis_pkg::ST_FULL;
                            n_member = 1'b0;
                        end else begin
                            bkt_we    = 1'b1;
                            bkt_wdata = '{v: 1'b1, key: r_item.key, link: '0};
                            n_held    = r_held + 1'b1;
                            n_status  = chis_pkg::ST_OK;
                            n_member  = 1'b1;
                        end
                    end else begin
                        n_status = chis_pkg::ST_MISS;
                        n_member = 1'b0;
                    end
                    n_state = S_OUT;
                end else if (r_bkt_q.key == r_item.key) begin
                    if (r_item.cmd == chis_pkg::CMD_REMOVE) begin
                        if (r_bkt_q.link != '0) begin
                            node_raddr = NW'(r_bkt_q.link - 1'b1);
                            n_state    = S_HEADRM;
                        end else begin
                            bkt_we   = 1'b1;
                            n_held   = r_held - 1'b1;
                            n_status = chis_pkg::ST_OK;
                            n_member = 1'b0;
                            n_state  = S_OUT;
                        end
                    end else begin
                        // present: query says found, insert says duplicate
                        n_status = (r_item.cmd == chis_pkg::CMD_QUERY) ?
                                   chis_pkg::ST_OK : chis_pkg::ST_MISS;
                        n_member = 1'b1;
                        n_state  = S_OUT;
                    end
                end else if (r_bkt_q.link == '0) begin
                    miss = 1'b1;
                end else begin
                    node_raddr = NW'(r_bkt_q.link - 1'b1);
                    n_l        = r_bkt_q.link;
                    n_prev     = '0;
                    n_state    = S_NODE;
                end
            end
            S_NODE: begin
                if (r_nkey_q == r_item.key) begin
                    if (r_item.cmd == chis_pkg::CMD_REMOVE) begin
                        if (r_prev == '0) begin
                            bkt_we    = 1'b1;
                            bkt_wdata = '{v: 1'b1, key: r_hk, link: r_nlnk_q};
                            n_hl      = r_nlnk_q;
                        end else begin
                            nlnk_we    = 1'b1;
                            node_waddr = NW'(r_prev - 1'b1);
                            node_wlink = r_nlnk_q;
                        end
                        free_go  = 1'b1;
                        free_n   = NW'(r_l - 1'b1);
                        n_held   = r_held - 1'b1;
                        n_status = chis_pkg::ST_OK;
                        n_member = 1'b0;
                    end else begin
                        n_status = (r_item.cmd == chis_pkg::CMD_QUERY) ?
                                   chis_pkg::ST_OK : chis_pkg::ST_MISS;
                        n_member = 1'b1;
                    end
                    n_state = S_OUT;
                end else if (r_nlnk_q == '0) begin
                    miss = 1'b1;
                end else begin
                    node_raddr = NW'(r_nlnk_q - 1'b1);
                    n_prev     = r_l;
                    n_l        = r_nlnk_q;
                end
            end
            S_HEADRM: begin
                // pull the first overflow node up into the bucket
                bkt_we    = 1'b1;
                bkt_wdata = '{v: 1'b1, key: r_nkey_q, link: r_nlnk_q};
                free_go   = 1'b1;
                free_n    = NW'(r_hl - 1'b1);
                n_held    = r_held - 1'b1;
                n_status  = chis_pkg::ST_OK;
                n_member  = 1'b0;
                n_state   = S_OUT;
            end
            S_ALLOC: begin
                link_go = 1'b1;
                link_n  = r_stk_q;
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_member = r_member;
                    n_out_total  = r_held;
                    n_state      = S_IDLE;
                end
            end
            S_CLR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
                n_held    = '0;
                n_fresh   = '0;
                n_freed   = '0;
                if (r_clr_idx == chis_pkg::BKT_AW'(chis_pkg::BUCKET_DEPTH - 1)) begin
                    n_status = chis_pkg::ST_OK;
                    n_member = 1'b0;
                    n_state  = r_clr_res ? S_OUT : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // chain ended without the key
        if (miss) begin
            if (r_item.cmd == chis_pkg::CMD_INSERT) begin
                if (at_limit || none_free) begin
                    n_status = chis_pkg::ST_FULL;
                    n_member = 1'b0;
                    n_state  = S_OUT;
                end else if (r_freed != '0) begin
                    n_freed = r_freed - 1'b1;
                    n_state = S_ALLOC;
                end else begin
                    link_go = 1'b1;
                    link_n  = r_fresh[NW-1:0];
                    n_fresh = r_fresh + 1'b1;
                end
            end else begin
                n_status = chis_pkg::ST_MISS;
                n_member = 1'b0;
                n_state  = S_OUT;
            end
        end

        // new overflow node goes in directly behind the bucket head
        if (link_go) begin
            nkey_we    = 1'b1;
            nlnk_we    = 1'b1;
            node_waddr = link_n;
            node_wlink = hl_now;
            bkt_we     = 1'b1;
            bkt_wdata  = '{v: 1'b1, key: hk_now, link: LW'({1'b0, link_n}) + 1'b1};
            n_held     = r_held + 1'b1;
            n_status   = chis_pkg::ST_OK;
            n_member   = 1'b1;
            n_state    = S_OUT;
        end

        if (free_go) begin
            stk_we    = 1'b1;
            stk_wdata = free_n;
            n_freed   = r_freed + 1'b1;
        end

        if (i_cfg_clr) begin
            n_state   = S_CLR;
            n_clr_idx = '0;
            n_clr_res = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_idx   <= '0;
            r_clr_res   <= 1'b0;
            r_held      <= '0;
            r_fresh     <= '0;
            r_freed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_clr_res   <= n_clr_res;
            r_held      <= n_held;
            r_fresh     <= n_fresh;
            r_freed     <= n_freed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_hk         <= n_hk;
        r_hl         <= n_hl;
        r_l          <= n_l;
        r_prev       <= n_prev;
        r_status     <= n_status;
        r_member     <= n_member;
        r_out_status <= n_out_status;
        r_out_member <= n_out_member;
        r_out_total  <= n_out_total;
    end

    always_ff @(posedge i_clk) begin
        if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
        r_bkt_q <= bkt_mem[i_head.bucket];
    end

    always_ff @(posedge i_clk) begin
        if (nkey_we) nkey_mem[node_waddr] <= r_item.key;
        r_nkey_q <= nkey_mem[node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (nlnk_we) nlnk_mem[node_waddr] <= node_wlink;
        r_nlnk_q <= nlnk_mem[node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) stk_mem[r_freed[NW-1:0]] <= stk_wdata;
        r_stk_q <= stk_mem[stk_raddr];
    end

endmodule

@@ sv/chis_checker.sv @@
// Port-level checks for the chained hash integer set, bound to the top level.
// Depends on chained_hash_integer_set_core.
module chis_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        pready
);

    // a result waiting for the sink holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    a_full_not_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == 2'd2 |-> !m_axis_tdata[2])
        else $error("set full yet key reported as member");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[13:3] <= 11'd2047 && m_axis_tdata[15:14] == 2'b00)
        else $error("padding bits of result set");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

endmodule

bind chained_hash_integer_set_core chis_checker u_chis_checker (.*);
